/* hw/rtl/ptq_pkg.sv */
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared types and constants of the periodic timer queue.
// ----------------------------------------------------------------------------
package ptq_pkg;
	localparam int SLOTS     = 16;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int TIME_BITS = 48;
	localparam int ID_BITS   = 8;
	localparam int DLY_BITS  = 31;
	localparam int DIV_W     = $clog2(TIME_BITS);

	localparam logic [1:0] ST_ADDED = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_FIRED = 2'd2;
	localparam logic [1:0] ST_NONE  = 2'd3;

	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_CHECK = 1'b1;

	typedef struct packed {
		logic                 req_type;
		logic [ID_BITS-1:0]   timer_id;
		logic [DLY_BITS-1:0]  delay_ms;
		logic                 periodic;
		logic [TIME_BITS-1:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [ID_BITS-1:0]   fired_id;
		logic                 last;
		logic                 armed;
		logic [TIME_BITS-1:0] next_deadline;
	} rsp_t;
endpackage

/* hw/rtl/ptq_div.sv */
// ----------------------------------------------------------------------------
// ptq_div
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ptq_div
	import ptq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [TIME_BITS-1:0] dividend,
	input  logic [DLY_BITS-1:0]  divisor,
	output logic                 done,
	output logic [DLY_BITS-1:0]  rem
);
	logic                 run_q;
	logic                 done_q;
	logic [DIV_W-1:0]     cnt_q;
	logic [TIME_BITS-1:0] sh_q;
	logic [DLY_BITS-1:0]  dv_q;
	logic [DLY_BITS-1:0]  r_q;
	logic [DLY_BITS:0]    trial;
	logic [DLY_BITS-1:0]  r_nx;

	always_comb begin
		trial = {r_q, sh_q[TIME_BITS-1]};
		if (trial >= {1'b0, dv_q}) begin
			r_nx = DLY_BITS'(trial - {1'b0, dv_q});
		end else begin
			r_nx = trial[DLY_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go && !run_q) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_W'(TIME_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && !run_q) begin
			sh_q <= dividend;
			dv_q <= divisor;
			r_q  <= '0;
		end else if (run_q) begin
			sh_q <= {sh_q[TIME_BITS-2:0], 1'b0};
			r_q  <= r_nx;
		end
	end

	assign done = done_q;
	assign rem  = r_q;
endmodule

/* hw/rtl/periodic_timer_queue.sv */
// ----------------------------------------------------------------------------
// periodic_timer_queue
// Table of timers with add and check requests, shared remainder unit.
// ----------------------------------------------------------------------------
// An add keeps busy high through a slot sweep for the earliest deadline,
// then the result beat. A check with k firings, p of them periodic, takes
// k+1 rounds of slot sweep and pick, a run of the bit-serial remainder unit
// for each of the p periodic firings, a final deadline sweep and max(k,1)
// result beats on consecutive cycles. Results follow only after the whole
// request is done, since each beat carries the final deadline. Busy is high
// the whole time; the receiver cannot stall, every strobe is a taken beat.
module periodic_timer_queue
	import ptq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic strobe,
	output rsp_t rsp
);
	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PICK, S_DIV, S_MIN, S_EMIT} state_t;

	state_t               state_q;
	req_t                 req_q;
	logic [SLOTS-1:0]     valid_q;
	logic [SLOTS-1:0]     done_q;
	logic [TIME_BITS-1:0] exp_q [SLOTS];
	logic [DLY_BITS-1:0]  iv_q  [SLOTS];
	logic [ID_BITS-1:0]   id_q  [SLOTS];
	logic [ID_BITS-1:0]   fid_q [SLOTS];
	logic [SLOT_W-1:0]    idx_q;
	logic [SLOT_W-1:0]    pick_q;
	logic                 found_q;
	logic [TIME_BITS-1:0] best_q;
	logic [CNT_W-1:0]     nfire_q;
	logic [CNT_W-1:0]     eidx_q;
	logic [1:0]           add_st_q;
	logic                 div_go;
	logic                 div_done;
	logic [DLY_BITS-1:0]  div_rem;
	logic                 has_free;
	logic [SLOT_W-1:0]    free_idx;
	logic [TIME_BITS:0]   add_sum;
	logic [TIME_BITS-1:0] base;
	logic [TIME_BITS:0]   per_sum;
	logic [TIME_BITS-1:0] cur_exp;
	logic                 due_cand;
	logic                 min_cand;
	logic [CNT_W-1:0]     nres;

	always_comb begin
		has_free = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				has_free = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	assign add_sum  = {1'b0, req.now_ms} + {{(TIME_BITS + 1 - DLY_BITS){1'b0}}, req.delay_ms};
	assign base     = req_q.now_ms - {{(TIME_BITS - DLY_BITS){1'b0}}, div_rem};
	assign per_sum  = {1'b0, base} + {{(TIME_BITS + 1 - DLY_BITS){1'b0}}, iv_q[pick_q]};
	assign cur_exp  = exp_q[idx_q];
	assign due_cand = valid_q[idx_q] && !done_q[idx_q] && (cur_exp <= req_q.now_ms)
		&& (!found_q || (cur_exp < best_q));
	assign min_cand = valid_q[idx_q] && (!found_q || (cur_exp < best_q));
	assign div_go   = (state_q == S_PICK) && found_q && (iv_q[pick_q] != '0);
	assign nres     = (req_q.req_type == REQ_ADD || nfire_q == '0) ? CNT_W'(1) : nfire_q;

	ptq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (req_q.now_ms - best_q),
		.divisor  (iv_q[pick_q]),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			done_q  <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
			nfire_q <= '0;
			eidx_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						nfire_q <= '0;
						eidx_q  <= '0;
						done_q  <= '0;
						if (req.req_type == REQ_ADD) begin
							if (has_free) valid_q[free_idx] <= 1'b1;
							state_q <= S_MIN;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (due_cand) found_q <= 1'b1;
					if (idx_q == SLOT_W'(SLOTS - 1)) state_q <= S_PICK;
				end
				S_PICK: begin
					if (!found_q) begin
						state_q <= S_MIN;
					end else begin
						done_q[pick_q] <= 1'b1;
						nfire_q        <= nfire_q + 1'b1;
						found_q        <= 1'b0;
						if (iv_q[pick_q] == '0) begin
							valid_q[pick_q] <= 1'b0;
							state_q         <= S_SCAN;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) state_q <= S_SCAN;
				end
				S_MIN: begin
					idx_q <= idx_q + 1'b1;
					if (min_cand) found_q <= 1'b1;
					if (idx_q == SLOT_W'(SLOTS - 1)) state_q <= S_EMIT;
				end
				S_EMIT: begin
					eidx_q <= eidx_q + 1'b1;
					if (eidx_q == nres - 1'b1) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
			if (req.req_type == REQ_ADD) begin
				add_st_q <= has_free ? ST_ADDED : ST_FULL;
				if (has_free) begin
					exp_q[free_idx] <= add_sum[TIME_BITS] ? '1 : add_sum[TIME_BITS-1:0];
					iv_q[free_idx]  <= req.periodic ? req.delay_ms : '0;
					id_q[free_idx]  <= req.timer_id;
				end
			end
		end
		if ((state_q == S_SCAN && due_cand) || (state_q == S_MIN && min_cand)) begin
			best_q <= cur_exp;
			pick_q <= idx_q;
		end
		if (state_q == S_PICK && found_q) fid_q[nfire_q[SLOT_W-1:0]] <= id_q[pick_q];
		if (state_q == S_DIV && div_done) begin
			exp_q[pick_q] <= per_sum[TIME_BITS] ? '1 : per_sum[TIME_BITS-1:0];
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = (state_q == S_EMIT);

	always_comb begin
		rsp.last          = (eidx_q == nres - 1'b1);
		rsp.armed         = found_q;
		rsp.next_deadline = found_q ? best_q : '0;
		if (req_q.req_type == REQ_ADD) begin
			rsp.status   = add_st_q;
			rsp.fired_id = '0;
		end else if (nfire_q == '0) begin
			rsp.status   = ST_NONE;
			rsp.fired_id = '0;
		end else begin
			rsp.status   = ST_FIRED;
			rsp.fired_id = fid_q[eidx_q[SLOT_W-1:0]];
		end
	end

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("beat outside a request");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request not taken");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && rsp.last |=> !busy) else $error("busy after last beat");
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !rsp.last |=> strobe) else $error("gap in result beats");
endmodule
